// ===== hw/rtl/eoq_pkg.sv =====
// ----------------------------------------------------------------------------
// eoq_pkg
// Types, constants and control words shared by the elevator order queue.
// ----------------------------------------------------------------------------
package eoq_pkg;

    localparam int NUM_FLOORS = 4;
    localparam int FLOOR_W    = $clog2(NUM_FLOORS);
    localparam int CNT_W      = $clog2(NUM_FLOORS + 1);

    typedef logic [FLOOR_W-1:0]    floor_t;
    typedef logic [NUM_FLOORS-1:0] marks_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_RESET = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_DOWN = 2'd0,
        PH_UP   = 2'd1,
        PH_CAB  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_EXEC      = 3'd1,
        ST_SCAN_DOWN = 3'd2,
        ST_SCAN_UP   = 3'd3,
        ST_SCAN_CAB  = 3'd4,
        ST_FINISH    = 3'd5
    } state_t;

    typedef struct packed {
        logic   load_item;
        logic   exec;
        logic   scan_en;
        phase_t phase;
        logic   idx_clear;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_last;
        logic       out_free;
    } status_t;

    typedef struct packed {
        logic   stop_here;
        logic   orders_above;
        logic   orders_below;
        logic   head_valid;
        floor_t head_floor;
        logic   last_valid;
        floor_t last_floor;
        marks_t up_marks;
        marks_t down_marks;
        marks_t cab_marks;
    } result_t;

endpackage

// ===== hw/rtl/eoq_ctrl.sv =====
// ----------------------------------------------------------------------------
// eoq_ctrl
// Sequencer for the order queue: takes a word, runs the action, walks the
// three button sets one floor per cycle and hands the result to the output.
// ----------------------------------------------------------------------------
module eoq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output eoq_pkg::cmd_t    cmd,
    input  eoq_pkg::status_t status
);

    eoq_pkg::state_t state_reg;
    eoq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eoq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eoq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = eoq_pkg::ST_EXEC;
                end
            end
            eoq_pkg::ST_EXEC:
            begin
                if (status.action == eoq_pkg::ACT_SCAN)
                begin
                    state_next = eoq_pkg::ST_SCAN_DOWN;
                end
                else
                begin
                    state_next = eoq_pkg::ST_FINISH;
                end
            end
            eoq_pkg::ST_SCAN_DOWN:
            begin
                if (status.idx_last)
                begin
                    state_next = eoq_pkg::ST_SCAN_UP;
                end
            end
            eoq_pkg::ST_SCAN_UP:
            begin
                if (status.idx_last)
                begin
                    state_next = eoq_pkg::ST_SCAN_CAB;
                end
            end
            eoq_pkg::ST_SCAN_CAB:
            begin
                if (status.idx_last)
                begin
                    state_next = eoq_pkg::ST_FINISH;
                end
            end
            eoq_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = eoq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eoq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.scan_en   = 1'b0;
        cmd.phase     = eoq_pkg::PH_DOWN;
        cmd.idx_clear = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            eoq_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            eoq_pkg::ST_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.idx_clear = 1'b1;
            end
            eoq_pkg::ST_SCAN_DOWN:
            begin
                cmd.scan_en   = 1'b1;
                cmd.phase     = eoq_pkg::PH_DOWN;
                cmd.idx_clear = status.idx_last;
            end
            eoq_pkg::ST_SCAN_UP:
            begin
                cmd.scan_en   = 1'b1;
                cmd.phase     = eoq_pkg::PH_UP;
                cmd.idx_clear = status.idx_last;
            end
            eoq_pkg::ST_SCAN_CAB:
            begin
                cmd.scan_en   = 1'b1;
                cmd.phase     = eoq_pkg::PH_CAB;
                cmd.idx_clear = status.idx_last;
            end
            eoq_pkg::ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while the output register is occupied");

    a_scan_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eoq_pkg::ST_EXEC && status.action != eoq_pkg::ACT_SCAN)
        |=> state_reg == eoq_pkg::ST_FINISH)
        else $error("non-scan action did not go straight to finish");
`endif

endmodule

// ===== hw/rtl/eoq_datapath.sv =====
// ----------------------------------------------------------------------------
// eoq_datapath
// Holds the pending marks, the priority list and the last visited floor,
// and forms the result word from the state after each action.
// ----------------------------------------------------------------------------
module eoq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        action,
    input  logic              at_floor,
    input  eoq_pkg::floor_t   sensor_floor,
    input  eoq_pkg::marks_t   up_buttons,
    input  eoq_pkg::marks_t   down_buttons,
    input  eoq_pkg::marks_t   cab_buttons,
    input  logic              travel_down,
    input  eoq_pkg::cmd_t     cmd,
    output logic [1:0]        act_out,
    output logic              idx_last,
    output eoq_pkg::result_t  result
);

    // Latched word
    logic [1:0]      act_reg;
    logic            at_floor_reg;
    eoq_pkg::floor_t sensor_reg;
    eoq_pkg::marks_t up_btn_reg;
    eoq_pkg::marks_t down_btn_reg;
    eoq_pkg::marks_t cab_btn_reg;
    logic            tdown_reg;

    // Queue state
    eoq_pkg::marks_t up_pending_reg,   up_pending_next;
    eoq_pkg::marks_t down_pending_reg, down_pending_next;
    eoq_pkg::marks_t cab_pending_reg,  cab_pending_next;
    eoq_pkg::floor_t list_reg  [eoq_pkg::NUM_FLOORS];
    eoq_pkg::floor_t list_next [eoq_pkg::NUM_FLOORS];
    eoq_pkg::count_t count_reg, count_next;
    logic            visited_valid_reg, visited_valid_next;
    eoq_pkg::floor_t visited_floor_reg, visited_floor_next;
    eoq_pkg::floor_t idx_reg, idx_next;

    // Working signals
    logic            btn_bit;
    logic            in_list;
    logic            found;
    eoq_pkg::floor_t rm_pos;
    logic            stop;
    logic            above;
    logic            below;
    eoq_pkg::floor_t sf;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg      <= action;
            at_floor_reg <= at_floor;
            sensor_reg   <= sensor_floor;
            up_btn_reg   <= up_buttons;
            down_btn_reg <= down_buttons;
            cab_btn_reg  <= cab_buttons;
            tdown_reg    <= travel_down;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
        begin
            list_reg[i] <= list_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_pending_reg    <= '0;
            down_pending_reg  <= '0;
            cab_pending_reg   <= '0;
            count_reg         <= '0;
            visited_valid_reg <= 1'b0;
            visited_floor_reg <= '0;
            idx_reg           <= '0;
        end
        else
        begin
            up_pending_reg    <= up_pending_next;
            down_pending_reg  <= down_pending_next;
            cab_pending_reg   <= cab_pending_next;
            count_reg         <= count_next;
            visited_valid_reg <= visited_valid_next;
            visited_floor_reg <= visited_floor_next;
            idx_reg           <= idx_next;
        end
    end

    // Button bit under the scan index; the bottom floor has no down call and
    // the top floor no up call.
    always_comb
    begin
        btn_bit = 1'b0;
        case (cmd.phase)
            eoq_pkg::PH_DOWN: btn_bit = down_btn_reg[idx_reg] && (idx_reg != '0);
            eoq_pkg::PH_UP:   btn_bit = up_btn_reg[idx_reg] &&
                                  (idx_reg != eoq_pkg::FLOOR_W'(eoq_pkg::NUM_FLOORS - 1));
            eoq_pkg::PH_CAB:  btn_bit = cab_btn_reg[idx_reg];
            default:          btn_bit = 1'b0;
        endcase
    end

    always_comb
    begin
        in_list = 1'b0;
        found   = 1'b0;
        rm_pos  = '0;
        for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
        begin
            if (eoq_pkg::CNT_W'(i) < count_reg && list_reg[i] == idx_reg)
            begin
                in_list = 1'b1;
            end
            if (!found && eoq_pkg::CNT_W'(i) < count_reg &&
                list_reg[i] == visited_floor_reg)
            begin
                found  = 1'b1;
                rm_pos = eoq_pkg::FLOOR_W'(i);
            end
        end
    end

    always_comb
    begin
        up_pending_next    = up_pending_reg;
        down_pending_next  = down_pending_reg;
        cab_pending_next   = cab_pending_reg;
        count_next         = count_reg;
        visited_valid_next = visited_valid_reg;
        visited_floor_next = visited_floor_reg;
        for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
        begin
            list_next[i] = list_reg[i];
        end

        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_en)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        if (cmd.exec)
        begin
            case (act_reg)
                eoq_pkg::ACT_SCAN:
                begin
                    if (at_floor_reg)
                    begin
                        visited_valid_next = 1'b1;
                        visited_floor_next = sensor_reg;
                    end
                end
                eoq_pkg::ACT_CLEAR:
                begin
                    if (visited_valid_reg)
                    begin
                        up_pending_next[visited_floor_reg]   = 1'b0;
                        down_pending_next[visited_floor_reg] = 1'b0;
                        cab_pending_next[visited_floor_reg]  = 1'b0;
                        if (found)
                        begin
                            for (int j = 0; j < eoq_pkg::NUM_FLOORS - 1; j++)
                            begin
                                if (eoq_pkg::FLOOR_W'(j) >= rm_pos)
                                begin
                                    list_next[j] = list_reg[j + 1];
                                end
                            end
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                eoq_pkg::ACT_RESET:
                begin
                    up_pending_next   = '0;
                    down_pending_next = '0;
                    cab_pending_next  = '0;
                    count_next        = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (cmd.scan_en && btn_bit)
        begin
            case (cmd.phase)
                eoq_pkg::PH_DOWN: down_pending_next[idx_reg] = 1'b1;
                eoq_pkg::PH_UP:   up_pending_next[idx_reg]   = 1'b1;
                default:          cab_pending_next[idx_reg]  = 1'b1;
            endcase
            if (!in_list && count_reg < eoq_pkg::CNT_W'(eoq_pkg::NUM_FLOORS))
            begin
                list_next[count_reg[eoq_pkg::FLOOR_W-1:0]] = idx_reg;
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Result from the current state and the latched sensor and direction.
    always_comb
    begin
        sf    = sensor_reg;
        stop  = 1'b0;
        above = 1'b0;
        below = 1'b0;
        if (at_floor_reg)
        begin
            stop = (count_reg != '0 && list_reg[0] == sf) || cab_pending_reg[sf] ||
                   (tdown_reg ? down_pending_reg[sf] : up_pending_reg[sf]);
        end
        for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
        begin
            if (eoq_pkg::CNT_W'(i) < count_reg)
            begin
                if (!visited_valid_reg)
                begin
                    above = 1'b1;
                end
                else
                begin
                    if (list_reg[i] > visited_floor_reg)
                    begin
                        above = 1'b1;
                    end
                    if (list_reg[i] < visited_floor_reg)
                    begin
                        below = 1'b1;
                    end
                end
            end
        end
    end

    assign result.stop_here    = stop;
    assign result.orders_above = above;
    assign result.orders_below = below;
    assign result.head_valid   = (count_reg != '0);
    assign result.head_floor   = (count_reg != '0) ? list_reg[0] : '0;
    assign result.last_valid   = visited_valid_reg;
    assign result.last_floor   = visited_floor_reg;
    assign result.up_marks     = up_pending_reg;
    assign result.down_marks   = down_pending_reg;
    assign result.cab_marks    = cab_pending_reg;

    assign act_out  = act_reg;
    assign idx_last = (idx_reg == eoq_pkg::FLOOR_W'(eoq_pkg::NUM_FLOORS - 1));

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eoq_pkg::CNT_W'(eoq_pkg::NUM_FLOORS))
        else $error("priority list count beyond the number of floors");

    a_head_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= eoq_pkg::CNT_W'(2)) |-> (list_reg[0] != list_reg[1]))
        else $error("priority list holds the same floor twice");

    a_clear_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && act_reg == eoq_pkg::ACT_CLEAR && visited_valid_reg) |=>
        (!up_pending_reg[visited_floor_reg] && !down_pending_reg[visited_floor_reg] &&
         !cab_pending_reg[visited_floor_reg]))
        else $error("clear left marks at the last floor");
`endif

endmodule

// ===== hw/rtl/elevator_order_queue.sv =====
// ----------------------------------------------------------------------------
// elevator_order_queue
// Pending elevator calls with a first-come list of distinct floors.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid, in_ready | action, at_floor, sensor_floor, buttons,
//           |                    | travel_down
//   out     | out_valid,         | stop_here, orders_above/below, head,
//           | out_ready          | last floor, up/down/cab marks
//
// A scan word runs the action, walks the three button sets floor by floor
// and then loads the result register. Clear, reset and unused codes run the
// action and go straight to loading the result. The sequencer then returns
// to idle before it takes the next word.
// One word is in work at a time; the result register lets the next word be
// accepted while a result still waits for out_ready, but a finished word
// stalls in the last step until that register is free.
// Reset empties marks and list and forgets the last floor; no clearing pass.
// ----------------------------------------------------------------------------
module elevator_order_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      action,
    input  logic            at_floor,
    input  eoq_pkg::floor_t sensor_floor,
    input  eoq_pkg::marks_t up_buttons,
    input  eoq_pkg::marks_t down_buttons,
    input  eoq_pkg::marks_t cab_buttons,
    input  logic            travel_down,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            stop_here,
    output logic            orders_above,
    output logic            orders_below,
    output logic            head_valid,
    output eoq_pkg::floor_t head_floor,
    output logic            last_valid,
    output eoq_pkg::floor_t last_floor,
    output eoq_pkg::marks_t up_marks,
    output eoq_pkg::marks_t down_marks,
    output eoq_pkg::marks_t cab_marks
);

    eoq_pkg::cmd_t    cmd;
    eoq_pkg::status_t status;
    eoq_pkg::result_t result;
    eoq_pkg::result_t res_reg;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       act_q;
    logic             idx_last;

    eoq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    eoq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (action),
        .at_floor     (at_floor),
        .sensor_floor (sensor_floor),
        .up_buttons   (up_buttons),
        .down_buttons (down_buttons),
        .cab_buttons  (cab_buttons),
        .travel_down  (travel_down),
        .cmd          (cmd),
        .act_out      (act_q),
        .idx_last     (idx_last),
        .result       (result)
    );

    assign status.action   = act_q;
    assign status.idx_last = idx_last;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign stop_here    = res_reg.stop_here;
    assign orders_above = res_reg.orders_above;
    assign orders_below = res_reg.orders_below;
    assign head_valid   = res_reg.head_valid;
    assign head_floor   = res_reg.head_floor;
    assign last_valid   = res_reg.last_valid;
    assign last_floor   = res_reg.last_floor;
    assign up_marks     = res_reg.up_marks;
    assign down_marks   = res_reg.down_marks;
    assign cab_marks    = res_reg.cab_marks;

endmodule

// ===== tb/elevator_order_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_order_queue_tb
// Self-checking bench for the elevator order queue: a short table of words,
// some with known results, then random car trips mixed with random noise. Each
// result is compared with the known view of its row or else with an in-bench
// model of marks, floor list and last floor, with random idling on both channels.
// ----------------------------------------------------------------------------
module elevator_order_queue_tb;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         RAND_WORDS  = 1800;
    localparam int         CALM_BLOCK  = 150;
    localparam int         DRAIN_WAIT  = 30;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]      action;
        logic            at_floor;
        eoq_pkg::floor_t sensor_floor;
        eoq_pkg::marks_t up_buttons;
        eoq_pkg::marks_t down_buttons;
        eoq_pkg::marks_t cab_buttons;
        logic            travel_down;
    } call_word_t;

    typedef struct {
        call_word_t       word;
        bit               known;
        eoq_pkg::result_t view;
    } table_row_t;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            in_valid     = 1'b0;
    logic            in_ready;
    logic [1:0]      action       = eoq_pkg::ACT_SCAN;
    logic            at_floor     = 1'b0;
    eoq_pkg::floor_t sensor_floor = '0;
    eoq_pkg::marks_t up_buttons   = '0;
    eoq_pkg::marks_t down_buttons = '0;
    eoq_pkg::marks_t cab_buttons  = '0;
    logic            travel_down  = 1'b0;
    logic            out_valid;
    logic            out_ready    = 1'b0;
    logic            stop_here;
    logic            orders_above;
    logic            orders_below;
    logic            head_valid;
    eoq_pkg::floor_t head_floor;
    logic            last_valid;
    eoq_pkg::floor_t last_floor;
    eoq_pkg::marks_t up_marks;
    eoq_pkg::marks_t down_marks;
    eoq_pkg::marks_t cab_marks;

    // Model of the order state.
    eoq_pkg::marks_t up_q        = '0;
    eoq_pkg::marks_t dn_q        = '0;
    eoq_pkg::marks_t cab_q       = '0;
    eoq_pkg::floor_t order_fifo [eoq_pkg::NUM_FLOORS];
    int              order_cnt   = 0;
    bit              visit_ok    = 1'b0;
    eoq_pkg::floor_t visit_floor = '0;

    eoq_pkg::result_t due_views [$];
    table_row_t       dir_rows [$];
    int               mismatch_cnt = 0;
    int               cycle_cnt    = 0;
    bit               no_idle      = 1'b0;
    int               ready_left   = 0;
    int               car_pos      = 0;
    bit               car_at       = 1'b1;
    bit               car_down     = 1'b0;

    elevator_order_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .at_floor     (at_floor),
        .sensor_floor (sensor_floor),
        .up_buttons   (up_buttons),
        .down_buttons (down_buttons),
        .cab_buttons  (cab_buttons),
        .travel_down  (travel_down),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stop_here    (stop_here),
        .orders_above (orders_above),
        .orders_below (orders_below),
        .head_valid   (head_valid),
        .head_floor   (head_floor),
        .last_valid   (last_valid),
        .last_floor   (last_floor),
        .up_marks     (up_marks),
        .down_marks   (down_marks),
        .cab_marks    (cab_marks)
    );

    always #1 clk = ~clk;

    initial
    begin
        for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
        begin
            order_fifo[i] = '0;
        end
    end

    function automatic void queue_floor(input eoq_pkg::floor_t f);
        bit found;
        found = 1'b0;
        for (int i = 0; i < order_cnt; i++)
        begin
            if (order_fifo[i] == f)
                found = 1'b1;
        end
        if (!found && order_cnt < eoq_pkg::NUM_FLOORS)
        begin
            order_fifo[order_cnt] = f;
            order_cnt++;
        end
    endfunction

    // Applies one word to the model and returns the view that follows it.
    function automatic eoq_pkg::result_t advance_orders(input call_word_t w);
        eoq_pkg::result_t r;
        bit               seen;
        int               pos;
        eoq_pkg::floor_t  sf;
        r    = '0;
        sf   = w.sensor_floor;
        seen = w.at_floor && (int'(sf) < eoq_pkg::NUM_FLOORS);
        case (w.action)
            eoq_pkg::ACT_SCAN:
            begin
                if (seen)
                begin
                    visit_ok    = 1'b1;
                    visit_floor = sf;
                end
                // Down-hall first, then up-hall, then cab; this fixes the list order.
                for (int i = 1; i < eoq_pkg::NUM_FLOORS; i++)
                begin
                    if (w.down_buttons[i])
                    begin
                        dn_q[i] = 1'b1;
                        queue_floor(eoq_pkg::floor_t'(i));
                    end
                end
                for (int i = 0; i + 1 < eoq_pkg::NUM_FLOORS; i++)
                begin
                    if (w.up_buttons[i])
                    begin
                        up_q[i] = 1'b1;
                        queue_floor(eoq_pkg::floor_t'(i));
                    end
                end
                for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
                begin
                    if (w.cab_buttons[i])
                    begin
                        cab_q[i] = 1'b1;
                        queue_floor(eoq_pkg::floor_t'(i));
                    end
                end
            end
            eoq_pkg::ACT_CLEAR:
            begin
                if (visit_ok)
                begin
                    up_q[visit_floor]  = 1'b0;
                    dn_q[visit_floor]  = 1'b0;
                    cab_q[visit_floor] = 1'b0;
                    pos = -1;
                    for (int i = 0; i < order_cnt; i++)
                    begin
                        if (pos < 0 && order_fifo[i] == visit_floor)
                            pos = i;
                    end
                    if (pos >= 0)
                    begin
                        for (int j = pos; j + 1 < order_cnt; j++)
                        begin
                            order_fifo[j] = order_fifo[j + 1];
                        end
                        order_cnt--;
                        order_fifo[order_cnt] = '0;
                    end
                end
            end
            eoq_pkg::ACT_RESET:
            begin
                up_q      = '0;
                dn_q      = '0;
                cab_q     = '0;
                order_cnt = 0;
                for (int i = 0; i < eoq_pkg::NUM_FLOORS; i++)
                begin
                    order_fifo[i] = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (seen)
        begin
            if (order_cnt > 0 && order_fifo[0] == sf)
                r.stop_here = 1'b1;
            else if (cab_q[sf])
                r.stop_here = 1'b1;
            else if (w.travel_down)
                r.stop_here = dn_q[sf];
            else
                r.stop_here = up_q[sf];
        end

        // Before any floor is seen, every queued floor counts as above.
        for (int i = 0; i < order_cnt; i++)
        begin
            if (!visit_ok)
                r.orders_above = 1'b1;
            else
            begin
                if (order_fifo[i] > visit_floor)
                    r.orders_above = 1'b1;
                if (order_fifo[i] < visit_floor)
                    r.orders_below = 1'b1;
            end
        end

        r.head_valid = (order_cnt > 0);
        r.head_floor = (order_cnt > 0) ? order_fifo[0] : '0;
        r.last_valid = visit_ok;
        r.last_floor = visit_ok ? visit_floor : '0;
        r.up_marks   = up_q;
        r.down_marks = dn_q;
        r.cab_marks  = cab_q;
        return r;
    endfunction

    function automatic string show_view(input eoq_pkg::result_t v);
        return $sformatf({"stop=%0b above=%0b below=%0b head=%0b/%0d ",
                          "last=%0b/%0d up=%h dn=%h cab=%h"},
                         v.stop_here, v.orders_above, v.orders_below, v.head_valid,
                         v.head_floor, v.last_valid, v.last_floor, v.up_marks,
                         v.down_marks, v.cab_marks);
    endfunction

    function automatic int pick_pause();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic eoq_pkg::marks_t press_pattern();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return '0;
        if (pick < 8)
            return eoq_pkg::marks_t'(1) << $urandom_range(0, eoq_pkg::NUM_FLOORS - 1);
        return eoq_pkg::marks_t'($urandom);
    endfunction

    task automatic add_row(input logic [1:0] a, input logic at, input eoq_pkg::floor_t sf,
                           input eoq_pkg::marks_t up, input eoq_pkg::marks_t dn,
                           input eoq_pkg::marks_t cab, input logic td, input bit known,
                           input eoq_pkg::result_t v);
        table_row_t row;
        row.word  = '{action: a, at_floor: at, sensor_floor: sf, up_buttons: up,
                      down_buttons: dn, cab_buttons: cab, travel_down: td};
        row.known = known;
        row.view  = v;
        dir_rows.push_back(row);
    endtask

    // One step of a car trip: the car leaves a floor or arrives at the next one,
    // turning round at the ends, and the passengers press buttons on the way.
    task automatic next_trip_word(output call_word_t w);
        if ($urandom_range(0, 2) == 0)
        begin
            if (car_at)
                car_at = 1'b0;
            else
            begin
                if (car_down && car_pos == 0)
                    car_down = 1'b0;
                else if (!car_down && car_pos == eoq_pkg::NUM_FLOORS - 1)
                    car_down = 1'b1;
                car_pos = car_down ? car_pos - 1 : car_pos + 1;
                car_at  = 1'b1;
            end
        end
        w.at_floor     = car_at;
        w.sensor_floor = car_at ? eoq_pkg::floor_t'(car_pos)
                                : eoq_pkg::floor_t'($urandom_range(0,
                                                     eoq_pkg::NUM_FLOORS - 1));
        w.travel_down  = car_down;
        w.up_buttons   = press_pattern();
        w.down_buttons = press_pattern();
        w.cab_buttons  = press_pattern();
        if (car_at && $urandom_range(0, 2) == 0)
            w.action = eoq_pkg::ACT_CLEAR;
        else if ($urandom_range(0, 39) == 0)
            w.action = eoq_pkg::ACT_RESET;
        else if ($urandom_range(0, 49) == 0)
            w.action = ACT_SPARE;
        else
            w.action = eoq_pkg::ACT_SCAN;
    endtask

    task automatic send_word(input call_word_t w);
        int gap;
        gap = pick_pause();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= w.action;
        at_floor     <= w.at_floor;
        sensor_floor <= w.sensor_floor;
        up_buttons   <= w.up_buttons;
        down_buttons <= w.down_buttons;
        cab_buttons  <= w.cab_buttons;
        travel_down  <= w.travel_down;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    initial
    begin
        call_word_t       w;
        eoq_pkg::result_t pred;

        // Nothing visited yet: clear is a no-op and a blank scan shows nothing.
        add_row(eoq_pkg::ACT_CLEAR, 1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1, '0);
        // Buttons beyond the floors: down at floor 0 and up at the top are ignored.
        add_row(eoq_pkg::ACT_SCAN, 1'b0, 2'd0, 4'h8, 4'h1, 4'h0, 1'b0, 1'b1, '0);
        // Cab call at floor 0 before any floor is seen counts as above.
        add_row(eoq_pkg::ACT_SCAN, 1'b0, 2'd0, 4'h0, 4'h0, 4'h1, 1'b0, 1'b1,
                {1'b0, 1'b1, 1'b0, 1'b1, 2'd0, 1'b0, 2'd0, 4'h0, 4'h0, 4'h1});
        add_row(eoq_pkg::ACT_CLEAR, 1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        // Reset keeps the last floor.
        add_row(eoq_pkg::ACT_RESET, 1'b1, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1,
                {1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 2'd0, 4'h0, 4'h0, 4'h0});
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd3, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_CLEAR, 1'b1, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        add_row(ACT_SPARE, 1'b1, 2'd1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0, '0);
        add_row(eoq_pkg::ACT_CLEAR, 1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd3, 4'h0, 4'h8, 4'h0, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_CLEAR, 1'b1, 2'd3, 4'h0, 4'h0, 4'h0, 1'b1, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b0, 2'd3, 4'h0, 4'h0, 4'hF, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_RESET, 1'b0, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1,
                {1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 2'd3, 4'h0, 4'h0, 4'h0});
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd1, 4'h1, 4'h0, 4'h0, 1'b1, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b0, 2'd1, 4'h0, 4'h8, 4'h0, 1'b1, 1'b0, '0);
        add_row(eoq_pkg::ACT_SCAN, 1'b1, 2'd3, 4'h0, 4'h0, 4'h0, 1'b1, 1'b0, '0);
        add_row(ACT_SPARE, 1'b0, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0, '0);
        add_row(eoq_pkg::ACT_RESET, 1'b1, 2'd1, 4'h0, 4'h0, 4'h0, 1'b1, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < dir_rows.size(); k++)
        begin
            send_word(dir_rows[k].word);
            pred = advance_orders(dir_rows[k].word);
            due_views.push_back(dir_rows[k].known ? dir_rows[k].view : pred);
        end

        for (int k = 0; k < RAND_WORDS; k++)
        begin
            // Some blocks run with both sides flat out.
            if (k % CALM_BLOCK == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
                next_trip_word(w);
            else
            begin
                w.action       = 2'($urandom_range(0, 3));
                w.at_floor     = 1'($urandom_range(0, 1));
                w.sensor_floor = eoq_pkg::floor_t'($urandom_range(0,
                                                   eoq_pkg::NUM_FLOORS - 1));
                w.up_buttons   = eoq_pkg::marks_t'($urandom);
                w.down_buttons = eoq_pkg::marks_t'($urandom);
                w.cab_buttons  = eoq_pkg::marks_t'($urandom);
                w.travel_down  = 1'($urandom_range(0, 1));
            end
            send_word(w);
            due_views.push_back(advance_orders(w));
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (due_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        eoq_pkg::result_t got;
        eoq_pkg::result_t exp_view;
        bit               bad;
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.stop_here    = stop_here;
            got.orders_above = orders_above;
            got.orders_below = orders_below;
            got.head_valid   = head_valid;
            got.head_floor   = head_floor;
            got.last_valid   = last_valid;
            got.last_floor   = last_floor;
            got.up_marks     = up_marks;
            got.down_marks   = down_marks;
            got.cab_marks    = cab_marks;
            if (due_views.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word: %s", show_view(got));
            end
            else
            begin
                exp_view = due_views.pop_front();
                bad = (got.stop_here    !== exp_view.stop_here)    ||
                      (got.orders_above !== exp_view.orders_above) ||
                      (got.orders_below !== exp_view.orders_below) ||
                      (got.head_valid   !== exp_view.head_valid)   ||
                      (got.head_floor   !== exp_view.head_floor)   ||
                      (got.last_valid   !== exp_view.last_valid)   ||
                      (got.last_floor   !== exp_view.last_floor)   ||
                      (got.up_marks     !== exp_view.up_marks)     ||
                      (got.down_marks   !== exp_view.down_marks)   ||
                      (got.cab_marks    !== exp_view.cab_marks);
                if (bad)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch expected: %s", show_view(exp_view));
                        $display("         actual:   %s", show_view(got));
                    end
                end
            end
        end

        // Receiver back-pressure: random stretches of ready and of stall.
        if (ready_left > 0)
            ready_left--;
        else if (no_idle)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_ready  <= 1'b0;
            ready_left = pick_pause();
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_left = $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
